FILE: src/icl16_pkg.sv
// Package with shared constants and types of the sixteen-line interrupt controller.
`timescale 1ns / 1ps

package icl16_pkg;

    localparam int LINE_COUNT = 16;
    localparam int LINE_W     = 4;
    localparam int WORD_W     = 16;
    localparam int LNUM_W     = 8;
    localparam int REG_IDX_W  = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [WORD_W-1:0] IRQ_MASK_RESET    = 16'hFFFF;
    localparam logic [WORD_W-1:0] VECTOR_BASE_RESET = 16'h0000;

    localparam logic [REG_IDX_W-1:0] REG_IRQ_MASK    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_VECTOR_BASE = 2'd1;

    typedef enum logic
    {
        FUNC_RAISE  = 1'b0,
        FUNC_UPDATE = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t             func;
        logic [LNUM_W-1:0] line_number;
        logic [WORD_W-1:0] eoi_mask;
    } request_t;

    typedef struct packed
    {
        logic [WORD_W-1:0] pending_word;
        logic [WORD_W-1:0] service_word;
        logic              dispatch_valid;
        logic [WORD_W-1:0] vector;
    } result_t;

endpackage

FILE: src/icl16_eval.sv
// Combinational evaluation of one request against the pending and in-service words.
`timescale 1ns / 1ps

module icl16_eval
(
    input  icl16_pkg::request_t            req,
    input  logic [icl16_pkg::WORD_W-1:0]   pending,
    input  logic [icl16_pkg::WORD_W-1:0]   service,
    input  logic [icl16_pkg::WORD_W-1:0]   irq_mask,
    input  logic [icl16_pkg::WORD_W-1:0]   vector_base,
    output icl16_pkg::result_t             result
);

    logic [icl16_pkg::WORD_W-1:0] raise_bit;
    logic [icl16_pkg::WORD_W-1:0] service_cleared;
    logic [icl16_pkg::WORD_W-1:0] ready;
    logic [icl16_pkg::WORD_W-1:0] lowest;
    logic [icl16_pkg::LINE_W-1:0] line_idx;

    always_comb
    begin
        raise_bit = '0;
        if (req.line_number < icl16_pkg::LNUM_W'(icl16_pkg::LINE_COUNT))
        begin
            raise_bit[req.line_number[icl16_pkg::LINE_W-1:0]] = 1'b1;
        end
        raise_bit = raise_bit & ~irq_mask;
    end

    assign service_cleared = service & ~req.eoi_mask;
    assign ready           = pending & ~irq_mask & ~service_cleared;
    assign lowest          = ready & (~ready + icl16_pkg::WORD_W'(1));

    always_comb
    begin
        line_idx = '0;
        for (int i = 0; i < icl16_pkg::LINE_COUNT; i++)
        begin
            if (lowest[i])
            begin
                line_idx = line_idx | icl16_pkg::LINE_W'(i);
            end
        end
    end

    always_comb
    begin
        unique case (req.func)
            icl16_pkg::FUNC_RAISE:
            begin
                result.pending_word   = pending | raise_bit;
                result.service_word   = service;
                result.dispatch_valid = 1'b0;
                result.vector         = '0;
            end
            icl16_pkg::FUNC_UPDATE:
            begin
                result.pending_word   = pending & ~lowest;
                result.service_word   = service_cleared | lowest;
                result.dispatch_valid = (ready != '0);
                result.vector         = (ready != '0)
                    ? vector_base + {{(icl16_pkg::WORD_W-icl16_pkg::LINE_W){1'b0}}, line_idx}
                    : '0;
            end
            default:
            begin
                result.pending_word   = pending;
                result.service_word   = service;
                result.dispatch_valid = 1'b0;
                result.vector         = '0;
            end
        endcase
    end

endmodule

FILE: src/interrupt_controller_16_line_top.sv
// Top level of the sixteen-line interrupt controller with stream ports and register writes.
// Path: an accepted request waits in the input register until it moves into the result register.
// Throughput: one request per cycle unless m_axis_tready stalls the output; the two registers
// form a two-stage pipeline, and the state words update as a request leaves the first stage.
// Reset: rst_n clears both stages, the pending and in-service words, sets irq_mask to
// all ones and vector_base to zero.
`timescale 1ns / 1ps

module interrupt_controller_16_line_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [icl16_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [icl16_pkg::WORD_W-1:0]         cfg_data,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: line_number[7:0], eoi_mask[23:8].
    input  logic [icl16_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0: func.
    input  logic                                 s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: pending_word[15:0], service_word[31:16], vector[47:32].
    output logic [icl16_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0: dispatch_valid.
    output logic                                 m_axis_tuser
);

    logic [icl16_pkg::WORD_W-1:0] irq_mask_reg;
    logic [icl16_pkg::WORD_W-1:0] vector_base_reg;
    logic [icl16_pkg::WORD_W-1:0] pending_reg;
    logic [icl16_pkg::WORD_W-1:0] service_reg;

    logic                         in_valid_reg;
    icl16_pkg::request_t          in_req_reg;
    logic                         out_valid_reg;
    icl16_pkg::result_t           out_res_reg;

    icl16_pkg::request_t          req_next;
    icl16_pkg::result_t           res_next;
    logic                         advance;
    logic                         s_accept;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign req_next.func        = icl16_pkg::func_t'(s_axis_tuser);
    assign req_next.line_number = s_axis_tdata[icl16_pkg::LNUM_W-1:0];
    assign req_next.eoi_mask    = s_axis_tdata[icl16_pkg::IN_DATA_W-1:icl16_pkg::LNUM_W];

    icl16_eval u_eval
    (
        .req         (in_req_reg),
        .pending     (pending_reg),
        .service     (service_reg),
        .irq_mask    (irq_mask_reg),
        .vector_base (vector_base_reg),
        .result      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_mask_reg    <= icl16_pkg::IRQ_MASK_RESET;
            vector_base_reg <= icl16_pkg::VECTOR_BASE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == icl16_pkg::REG_IRQ_MASK)
            begin
                irq_mask_reg <= cfg_data;
            end
            else if (cfg_index == icl16_pkg::REG_VECTOR_BASE)
            begin
                vector_base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
            service_reg   <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pending_reg   <= res_next.pending_word;
                service_reg   <= res_next.service_word;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_req_reg <= req_next;
        end
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.vector, out_res_reg.service_word,
                            out_res_reg.pending_word};
    assign m_axis_tuser  = out_res_reg.dispatch_valid;

    // A dispatched request always leaves at least one line in service.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (out_res_reg.service_word != '0))
        else $error("Dispatch reported with an empty in-service word.");

    // A result without a dispatch carries a zero vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (out_res_reg.vector == '0))
        else $error("Nonzero vector on a result without a dispatch.");

    // The state words change only when a request moves into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(pending_reg) && $stable(service_reg)))
        else $error("State words changed without a request completing.");

    // The newest result shows the current state when no request is waiting behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !in_valid_reg) |->
            (out_res_reg.pending_word == pending_reg && out_res_reg.service_word == service_reg))
        else $error("Result words disagree with the state words.");

    // An empty pipeline always takes a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid_reg && !out_valid_reg) |-> s_axis_tready)
        else $error("Idle block does not accept a request.");

endmodule
